// ===== rtl/core/complex_arith_unit_defines.svh =====
// ----------------------------------------------------------------------------
// complex_arith_unit_defines: shared assertion macros
// Assertions are clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// ante true implies cons true in the same cycle
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante true implies cons true in the next cycle
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Operation and status codes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cau_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_MAG = 3'd4
  } act_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_RSVD = 2'd3;

endpackage

// ===== rtl/core/cau_div_step.sv =====
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring division step: shift in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_div_step #(
  parameter int RW = 64
) (
  input  logic [RW-1:0] rem,
  input  logic [RW-1:0] den,
  input  logic          nbit,
  output logic [RW-1:0] rem_nxt,
  output logic          qbit
);

  logic [RW:0] r2;
  logic [RW:0] diff;

  always_comb begin
    r2      = {rem, nbit};
    diff    = r2 - {1'b0, den};
    qbit    = (r2 >= {1'b0, den});
    rem_nxt = qbit ? diff[RW-1:0] : r2[RW-1:0];
  end

endmodule

// ===== rtl/core/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex ALU in signed fixed point: add, sub, mul, div, magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_action and operands A, B
//   (signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS). Result channel
//   out_valid/out_ready returns out_res_re, out_res_im and out_status
//   (0 ok, 1 saturated, 2 divide by zero). One result per input, in order.
//   Stages: operand register, multiplier stage, sum stage, divider setup,
//   DATA_WIDTH + 1 restoring divide steps (the square root runs its
//   DATA_WIDTH steps in the same stages), then the saturating output
//   register. The divide step chain sets the pipeline depth.
//   Throughput is one transfer per cycle on each side while out_ready is high.
//   Every stage has a valid bit; a stage loads when it is empty or the
//   stage after it moves, so bubbles collapse while out_ready is low and
//   the unit keeps accepting until the pipeline is full. Nothing is lost
//   or repeated during a stall.
//   Synchronous active-low reset clears all valid bits; no data is flushed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "complex_arith_unit_defines.svh"

module complex_arith_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_action,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic [1:0]                   out_status
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int MW = 2 * W;          // product / magnitude width
  localparam int QW = W + 1;          // quotient bits kept
  localparam int NW = MW + F;         // scaled numerator width
  localparam int HW = NW - QW;        // numerator bits above the quotient
  localparam int CW = (HW > MW) ? HW : MW;
  localparam int SRW = W + 2;         // square root remainder width
  localparam int NS = QW + 5;         // total stages
  localparam int PS = 3;              // divider setup stage index

  localparam logic [MW-1:0] LIM_NEG = {{(MW-1){1'b0}}, 1'b1} << (W - 1);
  localparam logic [MW-1:0] LIM_POS = LIM_NEG - {{(MW-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [2:0]     act;
    logic           re_neg;
    logic           im_neg;
    logic [MW-1:0]  re_mag;
    logic [MW-1:0]  im_mag;
    logic [MW-1:0]  den;
    logic [MW-1:0]  rem_re;
    logic [MW-1:0]  rem_im;
    logic [QW-1:0]  nlo_re;
    logic [QW-1:0]  nlo_im;
    logic [QW-1:0]  q_re;
    logic [QW-1:0]  q_im;
    logic           dovf_re;
    logic           dovf_im;
    logic           dz;
    logic [MW-1:0]  sq_s;
    logic [SRW-1:0] sq_rem;
    logic [W-1:0]   sq_root;
  } pipe_t;

  // saturate sign/magnitude to W bits; returns {overflow, value}
  function automatic logic [W:0] sat_f(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] lim;
    logic [MW-1:0] m;
    logic          ovf;
    lim = neg ? LIM_NEG : LIM_POS;
    ovf = (mag > lim);
    m   = ovf ? lim : mag;
    m   = neg ? (~m + {{(MW-1){1'b0}}, 1'b1}) : m;
    return {ovf, m[W-1:0]};
  endfunction

  // valid bits and per-stage load enables
  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: operand register
  logic [2:0]          s0_act_r;
  logic signed [W-1:0] s0_ar_r, s0_ai_r, s0_br_r, s0_bi_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_act_r <= in_action;
      s0_ar_r  <= in_a_re;
      s0_ai_r  <= in_a_im;
      s0_br_r  <= in_b_re;
      s0_bi_r  <= in_b_im;
    end
  end

  // stage 1: products and add/sub
  logic [2:0]           s1_act_r;
  logic signed [MW-1:0] s1_p_r [4];
  logic signed [MW-1:0] s1_d_r [2];
  logic signed [W:0]    s1_as_re_r, s1_as_im_r;
  logic signed [W-1:0]  m0b, m1b;
  logic signed [W:0]    as_re_nxt, as_im_nxt;

  always_comb begin
    // magnitude reuses the first two multipliers for ar^2 and ai^2
    m0b = (s0_act_r == cau_pkg::ACT_MAG) ? s0_ar_r : s0_br_r;
    m1b = (s0_act_r == cau_pkg::ACT_MAG) ? s0_ai_r : s0_bi_r;
    if (s0_act_r == cau_pkg::ACT_SUB) begin
      as_re_nxt = (W+1)'(s0_ar_r) - (W+1)'(s0_br_r);
      as_im_nxt = (W+1)'(s0_ai_r) - (W+1)'(s0_bi_r);
    end else begin
      as_re_nxt = (W+1)'(s0_ar_r) + (W+1)'(s0_br_r);
      as_im_nxt = (W+1)'(s0_ai_r) + (W+1)'(s0_bi_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_act_r   <= s0_act_r;
      s1_p_r[0]  <= MW'(s0_ar_r) * MW'(m0b);
      s1_p_r[1]  <= MW'(s0_ai_r) * MW'(m1b);
      s1_p_r[2]  <= MW'(s0_ar_r) * MW'(s0_bi_r);
      s1_p_r[3]  <= MW'(s0_ai_r) * MW'(s0_br_r);
      s1_d_r[0]  <= MW'(s0_br_r) * MW'(s0_br_r);
      s1_d_r[1]  <= MW'(s0_bi_r) * MW'(s0_bi_r);
      s1_as_re_r <= as_re_nxt;
      s1_as_im_r <= as_im_nxt;
    end
  end

  // stage 2: sums to sign/magnitude
  logic [2:0]        s2_act_r;
  logic              s2_re_neg_r, s2_im_neg_r;
  logic [MW-1:0]     s2_re_mag_r, s2_im_mag_r, s2_den_r;
  logic signed [MW:0] sum_re, sum_im, abs_re, abs_im;
  logic signed [W:0]  asa_re, asa_im;
  logic              re_neg_nxt, im_neg_nxt;
  logic [MW-1:0]     re_mag_nxt, im_mag_nxt;

  always_comb begin
    if (s1_act_r == cau_pkg::ACT_MUL) begin
      sum_re = (MW+1)'(s1_p_r[0]) - (MW+1)'(s1_p_r[1]);
      sum_im = (MW+1)'(s1_p_r[2]) + (MW+1)'(s1_p_r[3]);
    end else begin
      sum_re = (MW+1)'(s1_p_r[0]) + (MW+1)'(s1_p_r[1]);
      sum_im = (MW+1)'(s1_p_r[3]) - (MW+1)'(s1_p_r[2]);
    end
    abs_re = sum_re[MW] ? -sum_re : sum_re;
    abs_im = sum_im[MW] ? -sum_im : sum_im;
    asa_re = s1_as_re_r[W] ? -s1_as_re_r : s1_as_re_r;
    asa_im = s1_as_im_r[W] ? -s1_as_im_r : s1_as_im_r;

    re_neg_nxt = sum_re[MW];
    im_neg_nxt = sum_im[MW];
    re_mag_nxt = abs_re[MW-1:0];
    im_mag_nxt = abs_im[MW-1:0];
    if (s1_act_r == cau_pkg::ACT_ADD || s1_act_r == cau_pkg::ACT_SUB) begin
      re_neg_nxt = s1_as_re_r[W];
      im_neg_nxt = s1_as_im_r[W];
      re_mag_nxt = MW'($unsigned(asa_re));
      im_mag_nxt = MW'($unsigned(asa_im));
    end else if (s1_act_r == cau_pkg::ACT_MUL) begin
      // truncate toward zero on the magnitude
      re_mag_nxt = abs_re[MW-1:0] >> F;
      im_mag_nxt = abs_im[MW-1:0] >> F;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_act_r    <= s1_act_r;
      s2_re_neg_r <= re_neg_nxt;
      s2_im_neg_r <= im_neg_nxt;
      s2_re_mag_r <= re_mag_nxt;
      s2_im_mag_r <= im_mag_nxt;
      s2_den_r    <= MW'($unsigned(s1_d_r[0]) + $unsigned(s1_d_r[1]));
    end
  end

  // divide / square root setup, then one step per stage
  pipe_t pipe_r   [QW+1];
  pipe_t pipe_nxt [QW+1];
  logic [NW-1:0] n_re, n_im;

  always_comb begin
    n_re = NW'(s2_re_mag_r) << F;
    n_im = NW'(s2_im_mag_r) << F;
    pipe_nxt[0]         = '0;
    pipe_nxt[0].act     = s2_act_r;
    pipe_nxt[0].re_neg  = s2_re_neg_r;
    pipe_nxt[0].im_neg  = s2_im_neg_r;
    pipe_nxt[0].re_mag  = s2_re_mag_r;
    pipe_nxt[0].im_mag  = s2_im_mag_r;
    pipe_nxt[0].den     = s2_den_r;
    pipe_nxt[0].rem_re  = MW'(n_re[NW-1:QW]);
    pipe_nxt[0].rem_im  = MW'(n_im[NW-1:QW]);
    pipe_nxt[0].nlo_re  = n_re[QW-1:0];
    pipe_nxt[0].nlo_im  = n_im[QW-1:0];
    // quotient would not fit in QW bits: saturates anyway
    pipe_nxt[0].dovf_re = (CW'(n_re[NW-1:QW]) >= CW'(s2_den_r));
    pipe_nxt[0].dovf_im = (CW'(n_im[NW-1:QW]) >= CW'(s2_den_r));
    pipe_nxt[0].dz      = (s2_den_r == '0);
    pipe_nxt[0].sq_s    = s2_re_mag_r;
  end

  always_ff @(posedge clk) begin
    if (en[PS]) begin
      pipe_r[0] <= pipe_nxt[0];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [MW-1:0]  rre_nxt, rim_nxt;
    logic           qb_re, qb_im;

    cau_div_step #(.RW(MW)) u_step_re (
      .rem     (pipe_r[j].rem_re),
      .den     (pipe_r[j].den),
      .nbit    (pipe_r[j].nlo_re[QW-1]),
      .rem_nxt (rre_nxt),
      .qbit    (qb_re)
    );

    cau_div_step #(.RW(MW)) u_step_im (
      .rem     (pipe_r[j].rem_im),
      .den     (pipe_r[j].den),
      .nbit    (pipe_r[j].nlo_im[QW-1]),
      .rem_nxt (rim_nxt),
      .qbit    (qb_im)
    );

    always_comb begin : c_step
      logic [SRW+1:0] sr2;
      logic [SRW+1:0] trial;
      logic           sge;
      sr2   = {pipe_r[j].sq_rem, pipe_r[j].sq_s[MW-1 -: 2]};
      trial = (SRW+2)'({pipe_r[j].sq_root, 2'b01});
      sge   = (sr2 >= trial);
      pipe_nxt[j+1]        = pipe_r[j];
      pipe_nxt[j+1].rem_re = rre_nxt;
      pipe_nxt[j+1].rem_im = rim_nxt;
      pipe_nxt[j+1].nlo_re = pipe_r[j].nlo_re << 1;
      pipe_nxt[j+1].nlo_im = pipe_r[j].nlo_im << 1;
      pipe_nxt[j+1].q_re   = {pipe_r[j].q_re[QW-2:0], qb_re};
      pipe_nxt[j+1].q_im   = {pipe_r[j].q_im[QW-2:0], qb_im};
      // root has W digits; the last divide step leaves it alone
      if (j < W) begin
        pipe_nxt[j+1].sq_rem  = sge ? SRW'(sr2 - trial) : SRW'(sr2);
        pipe_nxt[j+1].sq_root = {pipe_r[j].sq_root[W-2:0], sge};
        pipe_nxt[j+1].sq_s    = pipe_r[j].sq_s << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (en[PS+j+1]) begin
        pipe_r[j+1] <= pipe_nxt[j+1];
      end
    end
  end

  // output stage: select and saturate
  logic [2:0]   out_act_r;
  logic [W-1:0] out_re_r, out_im_r;
  logic [1:0]   out_st_r;
  logic [W:0]   sat_re, sat_im;
  logic [W-1:0] re_nxt, im_nxt;
  logic [1:0]   st_nxt;
  pipe_t        pl;

  always_comb begin
    pl     = pipe_r[QW];
    sat_re = sat_f(pl.re_neg, pl.re_mag);
    sat_im = sat_f(pl.im_neg, pl.im_mag);
    re_nxt = '0;
    im_nxt = '0;
    st_nxt = cau_pkg::ST_OK;
    case (pl.act)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_MUL: begin
        re_nxt = sat_re[W-1:0];
        im_nxt = sat_im[W-1:0];
        st_nxt = (sat_re[W] || sat_im[W]) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
      end
      cau_pkg::ACT_DIV: begin
        if (pl.dz) begin
          st_nxt = cau_pkg::ST_DIVZ;
        end else begin
          sat_re = sat_f(pl.re_neg, pl.dovf_re ? {MW{1'b1}} : MW'(pl.q_re));
          sat_im = sat_f(pl.im_neg, pl.dovf_im ? {MW{1'b1}} : MW'(pl.q_im));
          re_nxt = sat_re[W-1:0];
          im_nxt = sat_im[W-1:0];
          st_nxt = (sat_re[W] || sat_im[W]) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        end
      end
      cau_pkg::ACT_MAG: begin
        sat_re = sat_f(1'b0, MW'(pl.sq_root));
        re_nxt = sat_re[W-1:0];
        st_nxt = sat_re[W] ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
      end
      default: begin
        st_nxt = cau_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_act_r <= pl.act;
      out_re_r  <= re_nxt;
      out_im_r  <= im_nxt;
      out_st_r  <= st_nxt;
    end
  end

  assign out_res_re = out_re_r;
  assign out_res_im = out_im_r;
  assign out_status = out_st_r;

  `CAU_ASSERT_IMP(a_divz_zero, out_valid && out_status == cau_pkg::ST_DIVZ,
    out_res_re == '0 && out_res_im == '0 && out_act_r == cau_pkg::ACT_DIV,
    "divide by zero result not zero")
  `CAU_ASSERT_IMP(a_mag_real, out_valid && out_act_r == cau_pkg::ACT_MAG,
    out_res_im == '0 && !out_res_re[W-1], "magnitude result malformed")
  `CAU_ASSERT_IMP(a_status_code, out_valid, out_status != cau_pkg::ST_RSVD,
    "reserved status code")
  `CAU_ASSERT_NEXT(a_stage_hold, v_r[NS-2] && !en[NS-1], v_r[NS-2],
    "stalled stage lost its item")

endmodule
